FILE: rtl/dto_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the duplicate-suppression table.
// Used by dto_cell and dedup_table_oldest_replace; no dependencies.
package dto_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [1:0] MODE_CLAIM    = 2'd0;
    localparam logic [1:0] MODE_CONTAINS = 2'd1;
    localparam logic [1:0] MODE_RELEASE  = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;

    // Query broadcast to every cell while a word is being worked on
    typedef struct packed {
        logic [31:0] request;
        logic [31:0] origin;
        logic [31:0] now;
    } t_query;

    // Result of the scan, handed from cell to cell
    typedef struct packed {
        logic        match_hit;
        t_idx        match_idx;
        logic        free_hit;
        t_idx        free_idx;
        logic [31:0] best_age;
        t_idx        best_idx;
    } t_carry;

    // Table update broadcast to every cell
    typedef struct packed {
        logic wr_en;
        logic clr_en;
        t_idx idx;
    } t_cmd;

    localparam t_carry CARRY_INIT = '{
        match_hit: 1'b0,
        match_idx: '0,
        free_hit:  1'b0,
        free_idx:  '0,
        best_age:  32'd0,
        best_idx:  '0
    };

endpackage

FILE: rtl/dto_cell.sv
`timescale 1ns / 1ps
// One slot of the table: holds a pair and its stamp, folds itself into the scan result.
// Depends on dto_pkg.
module dto_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dto_pkg::t_idx   i_idx,
    input  dto_pkg::t_query i_query,
    input  dto_pkg::t_cmd   i_cmd,
    input  dto_pkg::t_carry i_carry,
    output dto_pkg::t_carry o_carry
);
    import dto_pkg::*;

    logic        r_valid;
    logic [31:0] r_request;
    logic [31:0] r_origin;
    logic [31:0] r_stamp;
    t_carry      r_carry;
    t_carry      n_carry;
    logic [31:0] w_age;
    logic        w_sel;

    assign w_age = i_query.now - r_stamp;
    assign w_sel = (i_cmd.idx == i_idx);

    always_comb begin
        n_carry = i_carry;
        // keep the lowest match and the lowest free slot seen so far
        if (!i_carry.match_hit && r_valid && r_request == i_query.request
                && r_origin == i_query.origin) begin
            n_carry.match_hit = 1'b1;
            n_carry.match_idx = i_idx;
        end
        if (!i_carry.free_hit && !r_valid) begin
            n_carry.free_hit = 1'b1;
            n_carry.free_idx = i_idx;
        end
        // ties go to the later slot
        if (w_age >= i_carry.best_age) begin
            n_carry.best_age = w_age;
            n_carry.best_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.wr_en && w_sel) begin
            r_valid <= 1'b1;
        end else if (i_cmd.clr_en && w_sel) begin
            r_valid <= 1'b0;
        end
        if (i_cmd.wr_en && w_sel) begin
            r_request <= i_query.request;
            r_origin  <= i_query.origin;
            r_stamp   <= i_query.now;
        end
    end

    assign o_carry = r_carry;

endmodule

FILE: rtl/dedup_table_oldest_replace.sv
`timescale 1ns / 1ps
// Top level of the duplicate-suppression table: command port, sequencer and cell chain.
// Depends on dto_pkg and dto_cell.

// One word is taken when start is high and busy is low; busy then stays high
// through the scan and commit states, and the answer appears on o_answer with o_strobe
// for exactly one cycle, registered from the commit state; a new word may be started
// in the strobe cycle. The scan result ripples through the chain of cells, one cell
// per cycle, before the table update in the commit state. The answer cannot be held
// off: sample it whenever o_strobe is high. The valid marks clear at reset.
module dedup_table_oldest_replace (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_request_id,
    input  logic [31:0] i_origin_addr,
    input  logic [31:0] i_now_time,
    output logic        o_strobe,
    output logic        o_answer
);
    import dto_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_idx       r_count;
    logic [1:0] r_mode;
    t_query     r_query;
    logic       r_strobe;
    logic       r_answer;
    logic       n_answer;
    t_cmd       w_cmd;
    t_carry     w_carry [TABLE_ENTRIES+1];
    t_carry     w_result;

    assign w_carry[0] = CARRY_INIT;
    assign w_result   = w_carry[TABLE_ENTRIES];

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            dto_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (IDX_W'(gi)),
                .i_query (r_query),
                .i_cmd   (w_cmd),
                .i_carry (w_carry[gi]),
                .o_carry (w_carry[gi+1])
            );
        end
    endgenerate

    // decide the table update and the answer once the scan has reached the end
    always_comb begin
        w_cmd    = '{wr_en: 1'b0, clr_en: 1'b0, idx: '0};
        n_answer = 1'b0;
        if (r_state == ST_COMMIT) begin
            unique case (r_mode)
                MODE_CLAIM: begin
                    if (r_query.request != 32'd0 && !w_result.match_hit) begin
                        w_cmd.wr_en = 1'b1;
                        w_cmd.idx   = w_result.free_hit ? w_result.free_idx
                                                        : w_result.best_idx;
                        n_answer    = 1'b1;
                    end
                end
                MODE_CONTAINS: begin
                    n_answer = w_result.match_hit;
                end
                MODE_RELEASE: begin
                    w_cmd.clr_en = w_result.match_hit;
                    w_cmd.idx    = w_result.match_idx;
                end
                default: begin
                    n_answer = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (start) n_state = ST_SCAN;
            ST_SCAN:   if (r_count == t_idx'(TABLE_ENTRIES - 1)) n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_COMMIT);
            if (r_state == ST_SCAN) begin
                r_count <= r_count + t_idx'(1);
            end else begin
                r_count <= '0;
            end
        end
        // hold the word for the whole scan
        if (r_state == ST_IDLE && start) begin
            r_mode          <= i_mode;
            r_query.request <= i_request_id;
            r_query.origin  <= i_origin_addr;
            r_query.now     <= i_now_time;
        end
        if (r_state == ST_COMMIT) begin
            r_answer <= n_answer;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_answer = r_answer;

endmodule

FILE: rtl/dto_chk.sv
`timescale 1ns / 1ps
// Port-level checks on the command handshake and answer strobe of the table.
// Bound to dedup_table_oldest_replace; no package needed.
module dto_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe
);

    // an accepted word raises busy straight away
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after an accepted word");

    // the answer only shows once the word is finished
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("answer strobe while busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("answer strobe longer than one cycle");

    // every finished word yields exactly one answer
    a_done_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("word finished without an answer");

endmodule

bind dedup_table_oldest_replace dto_chk u_dto_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe)
);

FILE: sim/dedup_table_oldest_replace_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for dedup_table_oldest_replace: a directed table of words, then
// random claim / query / release traffic, each answer checked against a given answer
// or a table model. Depends on dto_pkg and the RTL of dedup_table_oldest_replace.
module dedup_table_oldest_replace_tb;
    import dto_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 400;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 2 * (TABLE_ENTRIES + 2) + 4;
    localparam int SHOWN_ERRORS = 10;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] req;
        logic [31:0] org;
        logic [31:0] t_now;
        bit          known;
        logic        ans;
    } t_row;

    typedef struct {
        int          seq;
        logic [1:0]  mode;
        logic [31:0] req;
        logic [31:0] org;
        logic        ans;
    } t_pending;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_mode;
    logic [31:0] i_request_id;
    logic [31:0] i_origin_addr;
    logic [31:0] i_now_time;
    logic        o_strobe;
    logic        o_answer;

    // Table model
    logic        seen_valid   [TABLE_ENTRIES];
    logic [31:0] seen_request [TABLE_ENTRIES];
    logic [31:0] seen_origin  [TABLE_ENTRIES];
    logic [31:0] seen_stamp   [TABLE_ENTRIES];

    t_pending pending_answers[$];
    t_row     directed_rows[$];
    logic [31:0] known_req[$];
    logic [31:0] known_org[$];

    int words_sent  = 0;
    int mismatches  = 0;
    int idle_cycles = 0;
    int n_claims    = 0;
    int n_recorded  = 0;
    int n_evictions = 0;
    int n_queries   = 0;
    int n_releases  = 0;
    int n_unused    = 0;

    dedup_table_oldest_replace dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_request_id (i_request_id),
        .i_origin_addr(i_origin_addr),
        .i_now_time   (i_now_time),
        .o_strobe     (o_strobe),
        .o_answer     (o_answer)
    );

    always #4 i_clk = ~i_clk;

    // Advance the table model by one word and return the answer it gives
    function automatic logic predict_answer(input logic [1:0] m, input logic [31:0] req,
                                            input logic [31:0] org, input logic [31:0] t_now);
        int          hit;
        int          slot;
        logic [31:0] age;
        logic [31:0] oldest;
        hit = -1;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
            if (seen_valid[i] && seen_request[i] == req && seen_origin[i] == org)
                hit = i;
        case (m)
            MODE_CLAIM: begin
                n_claims++;
                if (req == 32'd0 || hit >= 0)
                    return 1'b0;
                slot = -1;
                for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                    if (!seen_valid[i])
                        slot = i;
                // table full: take greatest wrap-safe age, ties to the highest index
                if (slot < 0) begin
                    n_evictions++;
                    oldest = 32'd0;
                    slot   = 0;
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        age = t_now - seen_stamp[i];
                        if (age >= oldest) begin
                            oldest = age;
                            slot   = i;
                        end
                    end
                end
                seen_valid[slot]   = 1'b1;
                seen_request[slot] = req;
                seen_origin[slot]  = org;
                seen_stamp[slot]   = t_now;
                n_recorded++;
                return 1'b1;
            end
            MODE_CONTAINS: begin
                n_queries++;
                return (hit >= 0);
            end
            MODE_RELEASE: begin
                n_releases++;
                if (hit >= 0)
                    seen_valid[hit] = 1'b0;
                return 1'b0;
            end
            default: begin
                n_unused++;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void add_row(input logic [1:0] m, input logic [31:0] req,
                                    input logic [31:0] org, input logic [31:0] t_now,
                                    input bit known, input logic ans);
        t_row r;
        r.mode  = m;
        r.req   = req;
        r.org   = org;
        r.t_now = t_now;
        r.known = known;
        r.ans   = ans;
        directed_rows.push_back(r);
    endfunction

    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 40)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hold start low for the gap, then present the word until it is taken
    task automatic issue_word(input logic [1:0] m, input logic [31:0] req,
                              input logic [31:0] org, input logic [31:0] t_now,
                              input bit known, input logic ans, input int gap);
        t_pending p;
        logic     model_ans;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_mode        <= m;
        i_request_id  <= req;
        i_origin_addr <= org;
        i_now_time    <= t_now;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        model_ans = predict_answer(m, req, org, t_now);
        p.seq  = words_sent;
        p.mode = m;
        p.req  = req;
        p.org  = org;
        p.ans  = known ? ans : model_ans;
        pending_answers.push_back(p);
        words_sent++;
    endtask

    // Answer checker: every strobe must match the oldest waiting word
    always @(posedge i_clk) begin
        t_pending p;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected answer %b with no word outstanding", o_answer);
            end else begin
                p = pending_answers.pop_front();
                if (o_answer !== p.ans) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("word %0d mode %0d req %h org %h: expected %b, got %b",
                                 p.seq, p.mode, p.req, p.org, p.ans, o_answer);
                end
            end
        end
    end

    // Watchdog: drop out if nothing is taken or answered for too long
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles, %0d answers outstanding",
                         IDLE_LIMIT, pending_answers.size());
                $display("dedup_table_oldest_replace verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [1:0]  m;
        logic [31:0] req;
        logic [31:0] org;
        logic [31:0] clock_ms;
        int          r;
        int          pick;
        bit          burst;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_mode        = MODE_CLAIM;
        i_request_id  = 32'd0;
        i_origin_addr = 32'd0;
        i_now_time    = 32'd0;
        burst         = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            seen_valid[i]   = 1'b0;
            seen_request[i] = 32'd0;
            seen_origin[i]  = 32'd0;
            seen_stamp[i]   = 32'd0;
        end

        // Empty table, refused claims, unused mode, claim / duplicate / release
        add_row(MODE_CONTAINS, 32'd5, 32'd7, 32'd0, 1, 1'b0);
        add_row(MODE_RELEASE,  32'd5, 32'd7, 32'd0, 1, 1'b0);
        add_row(MODE_CLAIM,    32'd0, 32'hFFFF_FFFF, 32'd3, 1, 1'b0);
        add_row(MODE_UNUSED,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0);
        add_row(MODE_CLAIM,    32'd1, 32'd0, 32'd0, 1, 1'b1);
        add_row(MODE_CLAIM,    32'd1, 32'd0, 32'd9, 1, 1'b0);
        add_row(MODE_CONTAINS, 32'd1, 32'd0, 32'd9, 1, 1'b1);
        add_row(MODE_RELEASE,  32'd1, 32'd0, 32'd9, 1, 1'b0);
        add_row(MODE_CLAIM,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1);
        // Fill the rest of the table at one time stamp
        for (int k = 1; k < TABLE_ENTRIES; k++)
            add_row(MODE_CLAIM, 32'h100 + k, 32'hA5A5_0000 + k, 32'd100, 0, 1'b0);
        // Full table: the wrapped stamp is oldest, then an all-equal tie
        add_row(MODE_CLAIM,    32'h0000_DEAD, 32'h0000_BEEF, 32'd100, 0, 1'b0);
        add_row(MODE_CONTAINS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100, 0, 1'b0);
        add_row(MODE_CLAIM,    32'h0000_CAFE, 32'h0000_0001, 32'd100, 0, 1'b0);
        add_row(MODE_CONTAINS, 32'h100 + TABLE_ENTRIES - 1,
                32'hA5A5_0000 + TABLE_ENTRIES - 1, 32'd100, 0, 1'b0);
        add_row(MODE_CONTAINS, 32'h100 + TABLE_ENTRIES - 2,
                32'hA5A5_0000 + TABLE_ENTRIES - 2, 32'd100, 0, 1'b0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            issue_word(directed_rows[i].mode, directed_rows[i].req, directed_rows[i].org,
                       directed_rows[i].t_now, directed_rows[i].known, directed_rows[i].ans,
                       pick_gap(1'b0));

        // Random traffic: many pairs already seen, clock starts just short of the wrap
        clock_ms = 32'hFFFF_FE00;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 19);
            if (r < 14)
                clock_ms = clock_ms + $urandom_range(0, 3);
            else if (r < 18)
                clock_ms = clock_ms + $urandom_range(4, 200);
            else if (r == 18)
                clock_ms = $urandom;

            req  = $urandom;
            org  = $urandom;
            pick = $urandom_range(0, 99);
            if (known_req.size() != 0 && pick < 70) begin
                r   = $urandom_range(0, known_req.size() - 1);
                req = known_req[r];
                org = known_org[r];
            end

            r = $urandom_range(0, 99);
            if (r < 45) begin
                m = MODE_CLAIM;
                if (pick >= 90) begin
                    req = 32'd0;
                end else if (pick < 50 || known_req.size() == 0) begin
                    req = $urandom;
                    org = $urandom;
                    known_req.push_back(req);
                    known_org.push_back(org);
                    if (known_req.size() > 32) begin
                        void'(known_req.pop_front());
                        void'(known_org.pop_front());
                    end
                end
            end else if (r < 75) begin
                m = MODE_CONTAINS;
            end else if (r < 95) begin
                m = MODE_RELEASE;
            end else begin
                m = MODE_UNUSED;
            end
            issue_word(m, req, org, clock_ms, 0, 1'b0, pick_gap(burst));
        end

        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words: %0d claims (%0d recorded, %0d by eviction), %0d queries,",
                 words_sent, n_claims, n_recorded, n_evictions, n_queries);
        $display("%0d releases, %0d unused-mode words; %0d mismatches",
                 n_releases, n_unused, mismatches);
        if (mismatches == 0)
            $display("dedup_table_oldest_replace verification clean");
        else
            $display("dedup_table_oldest_replace verification failed");
        $finish;
    end

endmodule
